// ----- hdl/pcb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pcb_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;

    localparam int CNT_W     = 13;
    localparam int SAMPLE_W  = 8;
    localparam int IDX_W     = 12;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 13;

    localparam logic [OP_W-1:0] OP_PRE     = 3'd0;
    localparam logic [OP_W-1:0] OP_TRIGGER = 3'd1;
    localparam logic [OP_W-1:0] OP_POST    = 3'd2;
    localparam logic [OP_W-1:0] OP_FINISH  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ    = 3'd4;
    localparam logic [OP_W-1:0] OP_RESTART = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_CFG   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_DONE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AFTER = 2'd1;

    localparam logic [CNT_W-1:0] TOTAL_RST = 13'd4096;
    localparam logic [CNT_W-1:0] AFTER_RST = 13'd4096;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ADDR = 3'b010,
        S_DATA = 3'b100
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/pcb_cmd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pcb_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [pcb_pkg::OP_W-1:0]      op;
    logic [pcb_pkg::SAMPLE_W-1:0]  sample;
    logic [pcb_pkg::IDX_W-1:0]     read_index;

    modport source (output valid, output op, output sample, output read_index, input ready);
    modport sink   (input valid, input op, input sample, input read_index, output ready);
endinterface

interface pcb_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [pcb_pkg::SAMPLE_W-1:0]  read_data;
    logic                          capture_done;
    logic [pcb_pkg::CNT_W-1:0]     progress;
    logic [pcb_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output read_data, output capture_done, output progress,
                    output status, input ready);
    modport sink   (input valid, input read_data, input capture_done, input progress,
                    input status, output ready);
endinterface

`default_nettype wire

// ----- hdl/pcb_sample_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pcb_sample_ram #(
    parameter int DEPTH = pcb_pkg::MAX_SAMPLES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [AW-1:0]                 wr_addr,
    input  wire logic [pcb_pkg::SAMPLE_W-1:0]  wr_data,
    input  wire logic                          rd_en,
    input  wire logic [AW-1:0]                 rd_addr,
    output logic      [pcb_pkg::SAMPLE_W-1:0]  rd_data
);

    logic [pcb_pkg::SAMPLE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/pretrigger_capture_buffer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Handshake   | Payload
// cmd     | in  | valid/ready | op[2:0], sample[7:0], read_index[11:0]
// rsp     | out | valid/ready | read_data[7:0], capture_done, progress[12:0], status[1:0]
// cfg     | in  | write only  | cfg_we, cfg_index[1:0], cfg_wdata[12:0]
//
// Every item except a successful read gives its result in the cycle after it is taken.
// A read of a finished capture with its index in range goes through index mapping, RAM read and result, in that order.
// Samples (pre and post) are taken one per cycle while rsp keeps up.
// cmd is held off while a read is in flight or the result register is full and stalled.
// Reset clears the capture state; sample RAM contents are never cleared.

module pretrigger_capture_buffer_core #(
    parameter int MAX_SAMPLES = pcb_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    pcb_cmd_if.sink                             cmd,
    pcb_rsp_if.source                           rsp,
    input  wire logic                           cfg_we,
    input  wire logic [pcb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pcb_pkg::CFG_W-1:0]      cfg_wdata
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = pcb_pkg::CNT_W;
    localparam int SW = pcb_pkg::SAMPLE_W;

    pcb_pkg::state_t state_reg, state_next;

    logic [CW-1:0] total_reg, after_reg, pre_reg, tot_m1_reg;
    logic          ok_reg;

    logic [CW-1:0] ring_head_reg, ring_head_next;
    logic [CW-1:0] ring_filled_reg, ring_filled_next;
    logic [CW-1:0] after_filled_reg, after_filled_next;
    logic [CW-1:0] post_addr_reg, post_addr_next;
    logic [CW-1:0] progress_reg, progress_next;
    logic          trig_reg, trig_next;
    logic          fin_reg, fin_next;

    // read pipeline
    logic [CW-1:0] lin_reg, pad_reg, wrap_reg;
    logic          hit_reg;
    logic [CW-1:0] rd_addr_c;
    logic          hit_c;

    logic          rsp_valid_reg;
    logic [SW-1:0] rsp_data_reg;
    logic          rsp_done_reg;
    logic [CW-1:0] rsp_prog_reg;
    logic [pcb_pkg::STATUS_W-1:0] rsp_status_reg;

    logic          load_rsp;
    logic [SW-1:0] load_data;
    logic          load_done;
    logic [CW-1:0] load_prog;
    logic [pcb_pkg::STATUS_W-1:0] load_status;

    logic          accept;
    logic          start_read;
    logic          clear_cap;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
    logic [SW-1:0] ram_rd_data;

    logic          cfg_ok_next;
    logic [CW-1:0] cfg_total_new, cfg_after_new;
    logic          cfg_hit;

    assign cmd.ready = (state_reg == pcb_pkg::S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = cmd.valid && cmd.ready;

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.read_data    = rsp_data_reg;
    assign rsp.capture_done = rsp_done_reg;
    assign rsp.progress     = rsp_prog_reg;
    assign rsp.status       = rsp_status_reg;

    // configuration: new values of both registers after this write
    always_comb
    begin
        cfg_total_new = total_reg;
        cfg_after_new = after_reg;
        cfg_hit       = 1'b0;
        unique case (cfg_index)
            pcb_pkg::CFG_TOTAL:
            begin
                cfg_total_new = cfg_wdata;
                cfg_hit       = 1'b1;
            end
            pcb_pkg::CFG_AFTER:
            begin
                cfg_after_new = cfg_wdata;
                cfg_hit       = 1'b1;
            end
            default:
            begin
                cfg_hit = 1'b0;
            end
        endcase
        cfg_ok_next = (cfg_after_new != '0) && (cfg_after_new <= cfg_total_new) &&
                      (32'(cfg_total_new) <= 32'(MAX_SAMPLES));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= pcb_pkg::TOTAL_RST;
            after_reg  <= pcb_pkg::AFTER_RST;
            pre_reg    <= pcb_pkg::TOTAL_RST - pcb_pkg::AFTER_RST;
            tot_m1_reg <= pcb_pkg::TOTAL_RST - CW'(1);
            ok_reg     <= (32'(pcb_pkg::TOTAL_RST) <= 32'(MAX_SAMPLES));
        end
        else if (cfg_we && cfg_hit)
        begin
            total_reg  <= cfg_total_new;
            after_reg  <= cfg_after_new;
            pre_reg    <= cfg_total_new - cfg_after_new;
            tot_m1_reg <= cfg_total_new - CW'(1);
            ok_reg     <= cfg_ok_next;
        end
    end

    // item decode and capture state update
    always_comb
    begin
        state_next        = state_reg;
        ring_head_next    = ring_head_reg;
        ring_filled_next  = ring_filled_reg;
        after_filled_next = after_filled_reg;
        post_addr_next    = post_addr_reg;
        progress_next     = progress_reg;
        trig_next         = trig_reg;
        fin_next          = fin_reg;
        clear_cap         = 1'b0;
        start_read        = 1'b0;
        wr_en             = 1'b0;
        wr_addr           = ring_head_reg;
        load_rsp          = 1'b0;
        load_data         = '0;
        load_status       = pcb_pkg::ST_OK;

        unique case (state_reg)
            pcb_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    load_rsp = 1'b1;
                    if (cmd.op == pcb_pkg::OP_RESTART)
                    begin
                        clear_cap = 1'b1;
                        if (!ok_reg)
                        begin
                            load_status = pcb_pkg::ST_BAD_CFG;
                        end
                    end
                    else if (!ok_reg)
                    begin
                        load_status = pcb_pkg::ST_BAD_CFG;
                    end
                    else
                    begin
                        case (cmd.op)
                            pcb_pkg::OP_PRE:
                            begin
                                if (!fin_reg && !trig_reg && pre_reg != '0)
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = ring_head_reg;
                                    ring_head_next = (ring_head_reg + CW'(1) >= pre_reg) ?
                                                     '0 : ring_head_reg + CW'(1);
                                    if (ring_filled_reg < pre_reg)
                                    begin
                                        ring_filled_next = ring_filled_reg + CW'(1);
                                        progress_next    = progress_reg + CW'(1);
                                    end
                                end
                            end
                            pcb_pkg::OP_TRIGGER:
                            begin
                                if (!fin_reg)
                                begin
                                    trig_next = 1'b1;
                                end
                            end
                            pcb_pkg::OP_POST:
                            begin
                                if (trig_reg && !fin_reg && after_filled_reg < after_reg)
                                begin
                                    wr_en             = 1'b1;
                                    wr_addr           = post_addr_reg;
                                    after_filled_next = after_filled_reg + CW'(1);
                                    post_addr_next    = post_addr_reg + CW'(1);
                                    progress_next     = progress_reg + CW'(1);
                                end
                            end
                            pcb_pkg::OP_FINISH:
                            begin
                                trig_next = 1'b1;
                                fin_next  = 1'b1;
                            end
                            pcb_pkg::OP_READ:
                            begin
                                if (!fin_reg)
                                begin
                                    load_status = pcb_pkg::ST_NOT_DONE;
                                end
                                else if (CW'(cmd.read_index) >= total_reg)
                                begin
                                    load_status = pcb_pkg::ST_RANGE;
                                end
                                else
                                begin
                                    load_rsp   = 1'b0;
                                    start_read = 1'b1;
                                    state_next = pcb_pkg::S_ADDR;
                                end
                            end
                            default:
                            begin
                                load_status = pcb_pkg::ST_OK;
                            end
                        endcase
                    end
                end
            end
            pcb_pkg::S_ADDR:
            begin
                state_next = pcb_pkg::S_DATA;
            end
            pcb_pkg::S_DATA:
            begin
                load_rsp   = 1'b1;
                load_data  = hit_reg ? ram_rd_data : '0;
                state_next = pcb_pkg::S_IDLE;
            end
            default:
            begin
                state_next = pcb_pkg::S_IDLE;
            end
        endcase

        if (clear_cap)
        begin
            ring_head_next    = '0;
            ring_filled_next  = '0;
            after_filled_next = '0;
            post_addr_next    = pre_reg;
            progress_next     = '0;
            trig_next         = 1'b0;
            fin_next          = 1'b0;
        end

        load_done = ok_reg && (after_filled_next >= after_reg);
        load_prog = progress_next;
    end

    // map reversed position to a RAM address
    always_comb
    begin
        rd_addr_c = lin_reg;
        hit_c     = 1'b1;
        if (lin_reg >= pre_reg)
        begin
            hit_c = lin_reg < post_addr_reg;
        end
        else if (pad_reg != '0)
        begin
            hit_c     = lin_reg >= pad_reg;
            rd_addr_c = lin_reg - pad_reg;
        end
        else if (lin_reg >= wrap_reg)
        begin
            rd_addr_c = lin_reg - wrap_reg;
        end
        else
        begin
            rd_addr_c = lin_reg + ring_head_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_read)
        begin
            lin_reg  <= tot_m1_reg - CW'(cmd.read_index);
            pad_reg  <= pre_reg - ring_filled_reg;
            wrap_reg <= pre_reg - ring_head_reg;
        end
        if (state_reg == pcb_pkg::S_ADDR)
        begin
            hit_reg <= hit_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pcb_pkg::S_IDLE;
            ring_head_reg    <= '0;
            ring_filled_reg  <= '0;
            after_filled_reg <= '0;
            post_addr_reg    <= pcb_pkg::TOTAL_RST - pcb_pkg::AFTER_RST;
            progress_reg     <= '0;
            trig_reg         <= 1'b0;
            fin_reg          <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else if (cfg_we && cfg_hit)
        begin
            // a write to a mapped register restarts the capture
            ring_head_reg    <= '0;
            ring_filled_reg  <= '0;
            after_filled_reg <= '0;
            post_addr_reg    <= cfg_total_new - cfg_after_new;
            progress_reg     <= '0;
            trig_reg         <= 1'b0;
            fin_reg          <= 1'b0;
            state_reg        <= state_next;
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            ring_head_reg    <= ring_head_next;
            ring_filled_reg  <= ring_filled_next;
            after_filled_reg <= after_filled_next;
            post_addr_reg    <= post_addr_next;
            progress_reg     <= progress_next;
            trig_reg         <= trig_next;
            fin_reg          <= fin_next;
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            rsp_data_reg   <= load_data;
            rsp_done_reg   <= load_done;
            rsp_prog_reg   <= load_prog;
            rsp_status_reg <= load_status;
        end
    end

    pcb_sample_ram #(
        .DEPTH (MAX_SAMPLES),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(wr_addr)),
        .wr_data (cmd.sample),
        .rd_en   (state_reg == pcb_pkg::S_ADDR),
        .rd_addr (AW'(rd_addr_c)),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

// ----- dv/pretrigger_capture_buffer_core_tb.sv -----
`timescale 1ns / 1ps

module pretrigger_capture_buffer_core_tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam int ITEM_TARGET = 1900;
    localparam int MEM_DEPTH   = pcb_pkg::MAX_SAMPLES_DEF;

    // op codes with no function in the block
    localparam logic [pcb_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [pcb_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;
    // register index outside the map
    localparam logic [pcb_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd2;

    typedef struct packed {
        logic [pcb_pkg::SAMPLE_W-1:0] data;
        logic                         done;
        logic [pcb_pkg::CNT_W-1:0]    progress;
        logic [pcb_pkg::STATUS_W-1:0] status;
    } capture_rsp_t;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_CHECK,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t                     kind;
        logic [pcb_pkg::OP_W-1:0]      op;
        logic [pcb_pkg::SAMPLE_W-1:0]  smp;
        logic [pcb_pkg::IDX_W-1:0]     idx;
        logic [pcb_pkg::CFG_IDX_W-1:0] reg_sel;
        logic [pcb_pkg::CFG_W-1:0]     reg_val;
        capture_rsp_t                  want;
    } dir_row_t;

    localparam capture_rsp_t NO_RSP = '0;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [pcb_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pcb_pkg::CFG_W-1:0]     cfg_wdata;

    pcb_cmd_if cmd_ch ();
    pcb_rsp_if rsp_ch ();

    pretrigger_capture_buffer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // shadow of the capture state
    logic [pcb_pkg::CNT_W-1:0]    cap_total;
    logic [pcb_pkg::CNT_W-1:0]    cap_after;
    logic [pcb_pkg::SAMPLE_W-1:0] sample_mem [MEM_DEPTH];
    int                           ring_ptr;
    int                           ring_count;
    int                           post_count;
    bit                           armed;
    bit                           frozen;

    capture_rsp_t rsp_expected_q [$];
    int unsigned  err_count = 0;
    int unsigned  items_sent;
    int unsigned  cycle_count = 0;
    int           burst_left;

    // directed part: at reset the ring is empty (total == after == 4096)
    dir_row_t dir_tab [0:28] = '{
        '{ROW_CHECK, pcb_pkg::OP_READ, 8'h00, 12'h000, pcb_pkg::CFG_TOTAL, 13'd0,
          '{8'h00, 1'b0, 13'd0, pcb_pkg::ST_NOT_DONE}},
        '{ROW_CHECK, pcb_pkg::OP_PRE, 8'hff, 12'h000, pcb_pkg::CFG_TOTAL, 13'd0,
          '{8'h00, 1'b0, 13'd0, pcb_pkg::ST_OK}},
        '{ROW_CHECK, pcb_pkg::OP_POST, 8'hff, 12'h000, pcb_pkg::CFG_TOTAL, 13'd0,
          '{8'h00, 1'b0, 13'd0, pcb_pkg::ST_OK}},
        '{ROW_CHECK, pcb_pkg::OP_TRIGGER, 8'h00, 12'h000, pcb_pkg::CFG_TOTAL, 13'd0,
          '{8'h00, 1'b0, 13'd0, pcb_pkg::ST_OK}},
        '{ROW_CHECK, pcb_pkg::OP_TRIGGER, 8'h00, 12'h000, pcb_pkg::CFG_TOTAL, 13'd0,
          '{8'h00, 1'b0, 13'd0, pcb_pkg::ST_OK}},
        '{ROW_CHECK, pcb_pkg::OP_POST, 8'hff, 12'h000, pcb_pkg::CFG_TOTAL, 13'd0,
          '{8'h00, 1'b0, 13'd1, pcb_pkg::ST_OK}},
        '{ROW_CHECK, pcb_pkg::OP_PRE, 8'h00, 12'h000, pcb_pkg::CFG_TOTAL, 13'd0,
          '{8'h00, 1'b0, 13'd1, pcb_pkg::ST_OK}},
        '{ROW_CHECK, OP_SPARE6, 8'h00, 12'h000, pcb_pkg::CFG_TOTAL, 13'd0,
          '{8'h00, 1'b0, 13'd1, pcb_pkg::ST_OK}},
        '{ROW_CHECK, OP_SPARE7, 8'hff, 12'hfff, pcb_pkg::CFG_TOTAL, 13'd0,
          '{8'h00, 1'b0, 13'd1, pcb_pkg::ST_OK}},
        '{ROW_CHECK, pcb_pkg::OP_FINISH, 8'h00, 12'h000, pcb_pkg::CFG_TOTAL, 13'd0,
          '{8'h00, 1'b0, 13'd1, pcb_pkg::ST_OK}},
        '{ROW_CHECK, pcb_pkg::OP_FINISH, 8'h00, 12'h000, pcb_pkg::CFG_TOTAL, 13'd0,
          '{8'h00, 1'b0, 13'd1, pcb_pkg::ST_OK}},
        '{ROW_CHECK, pcb_pkg::OP_POST, 8'h55, 12'h000, pcb_pkg::CFG_TOTAL, 13'd0,
          '{8'h00, 1'b0, 13'd1, pcb_pkg::ST_OK}},
        '{ROW_CHECK, pcb_pkg::OP_TRIGGER, 8'h00, 12'h000, pcb_pkg::CFG_TOTAL, 13'd0,
          '{8'h00, 1'b0, 13'd1, pcb_pkg::ST_OK}},
        '{ROW_CHECK, pcb_pkg::OP_READ, 8'h00, 12'hfff, pcb_pkg::CFG_TOTAL, 13'd0,
          '{8'hff, 1'b0, 13'd1, pcb_pkg::ST_OK}},
        '{ROW_CHECK, pcb_pkg::OP_READ, 8'h00, 12'h000, pcb_pkg::CFG_TOTAL, 13'd0,
          '{8'h00, 1'b0, 13'd1, pcb_pkg::ST_OK}},
        '{ROW_CFG,   pcb_pkg::OP_PRE, 8'h00, 12'h000, pcb_pkg::CFG_TOTAL, 13'd3, NO_RSP},
        '{ROW_CFG,   pcb_pkg::OP_PRE, 8'h00, 12'h000, pcb_pkg::CFG_AFTER, 13'd1, NO_RSP},
        '{ROW_ITEM,  pcb_pkg::OP_PRE, 8'ha5, 12'h000, pcb_pkg::CFG_TOTAL, 13'd0, NO_RSP},
        '{ROW_ITEM,  pcb_pkg::OP_PRE, 8'h5a, 12'h000, pcb_pkg::CFG_TOTAL, 13'd0, NO_RSP},
        '{ROW_ITEM,  pcb_pkg::OP_PRE, 8'h3c, 12'h000, pcb_pkg::CFG_TOTAL, 13'd0, NO_RSP},
        '{ROW_ITEM,  pcb_pkg::OP_FINISH, 8'h00, 12'h000, pcb_pkg::CFG_TOTAL, 13'd0, NO_RSP},
        '{ROW_CHECK, pcb_pkg::OP_READ, 8'h00, 12'h003, pcb_pkg::CFG_TOTAL, 13'd0,
          '{8'h00, 1'b0, 13'd2, pcb_pkg::ST_RANGE}},
        '{ROW_ITEM,  pcb_pkg::OP_READ, 8'h00, 12'h000, pcb_pkg::CFG_TOTAL, 13'd0, NO_RSP},
        '{ROW_ITEM,  pcb_pkg::OP_READ, 8'h00, 12'h001, pcb_pkg::CFG_TOTAL, 13'd0, NO_RSP},
        '{ROW_ITEM,  pcb_pkg::OP_READ, 8'h00, 12'h002, pcb_pkg::CFG_TOTAL, 13'd0, NO_RSP},
        '{ROW_CFG,   pcb_pkg::OP_PRE, 8'h00, 12'h000, pcb_pkg::CFG_AFTER, 13'd0, NO_RSP},
        '{ROW_CHECK, pcb_pkg::OP_PRE, 8'hff, 12'h000, pcb_pkg::CFG_TOTAL, 13'd0,
          '{8'h00, 1'b0, 13'd0, pcb_pkg::ST_BAD_CFG}},
        '{ROW_CHECK, pcb_pkg::OP_READ, 8'h00, 12'h000, pcb_pkg::CFG_TOTAL, 13'd0,
          '{8'h00, 1'b0, 13'd0, pcb_pkg::ST_BAD_CFG}},
        '{ROW_CHECK, pcb_pkg::OP_RESTART, 8'h00, 12'h000, pcb_pkg::CFG_TOTAL, 13'd0,
          '{8'h00, 1'b0, 13'd0, pcb_pkg::ST_BAD_CFG}}
    };

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void clear_capture();
        ring_ptr   = 0;
        ring_count = 0;
        post_count = 0;
        armed      = 1'b0;
        frozen     = 1'b0;
    endfunction

    function automatic bit cfg_valid();
        return cap_after >= 1 && cap_after <= cap_total && cap_total <= MEM_DEPTH;
    endfunction

    // capture state update for one item, returns the expected result
    function automatic capture_rsp_t step_capture(input logic [pcb_pkg::OP_W-1:0] op,
                                                  input logic [pcb_pkg::SAMPLE_W-1:0] smp,
                                                  input logic [pcb_pkg::IDX_W-1:0] idx);
        capture_rsp_t r;
        bit good;
        int pre_len;
        int lin;
        int pad;
        int addr;
        r = '0;
        good = cfg_valid();
        pre_len = int'(cap_total) - int'(cap_after);
        if (op == pcb_pkg::OP_RESTART)
        begin
            clear_capture();
            if (!good)
                r.status = pcb_pkg::ST_BAD_CFG;
        end
        else if (!good)
        begin
            r.status = pcb_pkg::ST_BAD_CFG;
        end
        else
        begin
            case (op)
                pcb_pkg::OP_PRE:
                    if (!frozen && !armed && pre_len > 0)
                    begin
                        sample_mem[ring_ptr] = smp;
                        ring_ptr = (ring_ptr + 1 >= pre_len) ? 0 : ring_ptr + 1;
                        if (ring_count < pre_len)
                            ring_count++;
                    end
                pcb_pkg::OP_TRIGGER:
                    if (!frozen)
                        armed = 1'b1;
                pcb_pkg::OP_POST:
                    if (armed && !frozen && post_count < int'(cap_after))
                    begin
                        sample_mem[pre_len + post_count] = smp;
                        post_count++;
                    end
                pcb_pkg::OP_FINISH:
                begin
                    armed  = 1'b1;
                    frozen = 1'b1;
                end
                pcb_pkg::OP_READ:
                    if (!frozen)
                        r.status = pcb_pkg::ST_NOT_DONE;
                    else if (int'(idx) >= int'(cap_total))
                        r.status = pcb_pkg::ST_RANGE;
                    else
                    begin
                        // output order is newest first
                        lin = int'(cap_total) - 1 - int'(idx);
                        if (lin >= pre_len)
                        begin
                            if (lin - pre_len < post_count)
                                r.data = sample_mem[lin];
                        end
                        else if (ring_count < pre_len)
                        begin
                            pad = pre_len - ring_count;
                            if (lin >= pad)
                                r.data = sample_mem[lin - pad];
                        end
                        else
                        begin
                            addr = ring_ptr + lin;
                            if (addr >= pre_len)
                                addr -= pre_len;
                            r.data = sample_mem[addr];
                        end
                    end
                default:
                    ;
            endcase
        end
        r.done = good && post_count >= int'(cap_after);
        r.progress = pcb_pkg::CNT_W'(ring_count + post_count);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        err_count++;
    endtask

    // entered and left just after a falling edge
    task automatic send_cmd(input logic [pcb_pkg::OP_W-1:0] op,
                            input logic [pcb_pkg::SAMPLE_W-1:0] smp,
                            input logic [pcb_pkg::IDX_W-1:0] idx, input bit typed,
                            input capture_rsp_t typed_rsp);
        capture_rsp_t predicted;
        int gap;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                cmd_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        cmd_ch.valid      = 1'b1;
        cmd_ch.op         = op;
        cmd_ch.sample     = smp;
        cmd_ch.read_index = idx;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        predicted = step_capture(op, smp, idx);
        rsp_expected_q.push_back(typed ? typed_rsp : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_noise();
        if ($urandom_range(0, 7) == 0)
            send_cmd(pcb_pkg::OP_W'($urandom_range(0, 7)),
                     pcb_pkg::SAMPLE_W'($urandom_range(0, 255)),
                     pcb_pkg::IDX_W'($urandom_range(0, 4095)), 1'b0, NO_RSP);
    endtask

    // wait until every result is back, then let the block go idle
    task automatic settle();
        cmd_ch.valid = 1'b0;
        while (rsp_expected_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [pcb_pkg::CFG_IDX_W-1:0] sel,
                             input logic [pcb_pkg::CFG_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = sel;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (sel == pcb_pkg::CFG_TOTAL)
        begin
            cap_total = val;
            clear_capture();
        end
        else if (sel == pcb_pkg::CFG_AFTER)
        begin
            cap_after = val;
            clear_capture();
        end
    endtask

    // receiver stall pattern
    initial
    begin : rsp_stall
        int mode;
        int mode_left;
        mode_left = 0;
        mode = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            case (mode)
                0, 1: rsp_ch.ready = 1'b1;
                2: rsp_ch.ready = 1'($urandom_range(0, 1));
                default: rsp_ch.ready = ($urandom_range(0, 3) == 0);
            endcase
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin : check_results
        capture_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (rsp_expected_q.size() == 0)
                report_mismatch("result with nothing pending", 1, 0);
            else
            begin
                want = rsp_expected_q.pop_front();
                if (rsp_ch.read_data !== want.data)
                    report_mismatch("read_data", rsp_ch.read_data, want.data);
                if (rsp_ch.capture_done !== want.done)
                    report_mismatch("capture_done", rsp_ch.capture_done, want.done);
                if (rsp_ch.progress !== want.progress)
                    report_mismatch("progress", rsp_ch.progress, want.progress);
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", rsp_ch.status, want.status);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[pretrigger_capture_buffer_core] ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int pick;
        int pre_len;
        int n_pre;
        int n_post;
        int n_rd;
        int lim;
        bit good;
        logic [pcb_pkg::CFG_W-1:0] new_total;
        logic [pcb_pkg::CFG_W-1:0] new_after;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.op         = pcb_pkg::OP_PRE;
        cmd_ch.sample     = '0;
        cmd_ch.read_index = '0;
        items_sent        = 0;
        burst_left        = 0;
        cap_total         = pcb_pkg::TOTAL_RST;
        cap_after         = pcb_pkg::AFTER_RST;
        clear_capture();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(dir_tab[i].reg_sel, dir_tab[i].reg_val);
            end
            else
                send_cmd(dir_tab[i].op, dir_tab[i].smp, dir_tab[i].idx,
                         dir_tab[i].kind == ROW_CHECK, dir_tab[i].want);
        end

        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 19);
            case (pick)
                0:
                begin
                    new_total = 13'd4096;
                    new_after = 13'd4096;
                end
                1:
                begin
                    new_total = 13'd4096;
                    new_after = 13'd1;
                end
                2:
                begin
                    new_total = 13'd1;
                    new_after = 13'd1;
                end
                3:
                begin
                    new_total = ($urandom_range(0, 2) == 0) ? 13'd0
                                : pcb_pkg::CFG_W'($urandom_range(0, 8191));
                    new_after = 13'd0;
                end
                4:
                begin
                    new_total = pcb_pkg::CFG_W'($urandom_range(0, 100));
                    new_after = new_total + pcb_pkg::CFG_W'($urandom_range(1, 50));
                end
                5:
                begin
                    new_total = ($urandom_range(0, 1) == 0) ? 13'd8191
                                : pcb_pkg::CFG_W'($urandom_range(4097, 8191));
                    new_after = ($urandom_range(0, 3) == 0) ? 13'd8191
                                : pcb_pkg::CFG_W'($urandom_range(1, 4096));
                end
                6:
                begin
                    new_total = pcb_pkg::CFG_W'($urandom_range(2, 4096));
                    new_after = pcb_pkg::CFG_W'($urandom_range(1, new_total));
                end
                default:
                begin
                    new_total = pcb_pkg::CFG_W'($urandom_range(1, 24));
                    new_after = pcb_pkg::CFG_W'($urandom_range(1, new_total));
                end
            endcase

            settle();
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(pcb_pkg::CFG_TOTAL, new_total);
                write_reg(pcb_pkg::CFG_AFTER, new_after);
            end
            else
            begin
                write_reg(pcb_pkg::CFG_AFTER, new_after);
                write_reg(pcb_pkg::CFG_TOTAL, new_total);
            end
            if ($urandom_range(0, 15) == 0)
                write_reg(CFG_SPARE, pcb_pkg::CFG_W'($urandom_range(0, 8191)));

            good = cfg_valid();
            pre_len = good ? int'(new_total) - int'(new_after) : 4;

            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 2) == 0)
                    send_cmd(pcb_pkg::OP_RESTART, '0, '0, 1'b0, NO_RSP);

                // pretrigger ring, often past full so it wraps
                lim = (pre_len * 2 + 2 > 40) ? 40 : pre_len * 2 + 2;
                n_pre = $urandom_range(0, lim);
                repeat (n_pre)
                begin
                    send_noise();
                    send_cmd(pcb_pkg::OP_PRE, pcb_pkg::SAMPLE_W'($urandom_range(0, 255)),
                             pcb_pkg::IDX_W'($urandom_range(0, 4095)), 1'b0, NO_RSP);
                end

                if ($urandom_range(0, 7) != 0)
                    send_cmd(pcb_pkg::OP_TRIGGER, '0, '0, 1'b0, NO_RSP);

                lim = good ? ((int'(new_after) + 2 > 40) ? 40 : int'(new_after) + 2) : 4;
                if (good && new_after <= 40 && $urandom_range(0, 1) == 0)
                    n_post = int'(new_after);
                else
                    n_post = $urandom_range(0, lim);
                repeat (n_post)
                begin
                    send_noise();
                    send_cmd(pcb_pkg::OP_POST, pcb_pkg::SAMPLE_W'($urandom_range(0, 255)),
                             pcb_pkg::IDX_W'($urandom_range(0, 4095)), 1'b0, NO_RSP);
                end

                if ($urandom_range(0, 9) != 0)
                    send_cmd(pcb_pkg::OP_FINISH, '0, '0, 1'b0, NO_RSP);

                if ($urandom_range(0, 5) == 0)
                    settle();

                n_rd = $urandom_range(1, 16);
                repeat (n_rd)
                begin
                    if (!good || $urandom_range(0, 5) == 0)
                        send_cmd(pcb_pkg::OP_READ, pcb_pkg::SAMPLE_W'($urandom_range(0, 255)),
                                 pcb_pkg::IDX_W'($urandom_range(0, 4095)), 1'b0, NO_RSP);
                    else
                        send_cmd(pcb_pkg::OP_READ, pcb_pkg::SAMPLE_W'($urandom_range(0, 255)),
                                 pcb_pkg::IDX_W'($urandom_range(0, int'(new_total) - 1)),
                                 1'b0, NO_RSP);
                end
            end
        end

        cmd_ch.valid = 1'b0;
        while (rsp_expected_q.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (err_count == 0)
            $display("[pretrigger_capture_buffer_core] OK");
        else
            $display("[pretrigger_capture_buffer_core] ERROR");
        $finish;
    end

endmodule
